@@ rtl/ffp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Feedback frame parser package
// Shared constants, status codes and the record phase type.
// ---------------------------------------------------------------------------
package ffp_pkg;

   // Record headers. An arm header is HDR_BASE minus the arm number.
   localparam logic [7:0] HDR_HEIGHT = 8'hEE;
   localparam logic [7:0] HDR_BASE   = 8'hFF;
   localparam logic [7:0] ARM_MIN    = 8'h01;
   localparam logic [7:0] ARM_MAX    = 8'h05;

   // Reset value of the position limit register.
   localparam logic [15:0] LIMIT_RESET = 16'd1000;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_HEIGHT   = 3'd0,
      ST_ARM_SET  = 3'd1,
      ST_REJECT   = 3'd2,
      ST_UNDEF    = 3'd3,
      ST_MISMATCH = 3'd4
   } status_type;

   // Position of the next byte within a four-byte record.
   typedef enum logic [1:0] {
      PH_HDR1 = 2'd0,
      PH_HDR2 = 2'd1,
      PH_LOW  = 2'd2,
      PH_HIGH = 2'd3
   } phase_type;

endpackage

@@ rtl/ffp_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Feedback frame parser request channel
// Valid/ready channel that carries one received byte per beat.
// ---------------------------------------------------------------------------
interface ffp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       batch_end;

   modport source (output valid, output rx_byte, output batch_end, input ready);
   modport sink   (input valid, input rx_byte, input batch_end, output ready);
endinterface

@@ rtl/ffp_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Feedback frame parser response channel
// Valid/ready channel that carries one parse result per beat.
// ---------------------------------------------------------------------------
interface ffp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [2:0]  arm_number;
   logic [15:0] value;

   modport source (output valid, output status, output arm_number, output value,
                   input ready);
   modport sink   (input valid, input status, input arm_number, input value,
                   output ready);
endinterface

@@ rtl/feedback_frame_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Feedback frame parser
// Byte-serial decoder for four-byte height and arm position records.
// ---------------------------------------------------------------------------
// The parser takes one received byte per beat on req and reports at most one
// result per byte on rsp, in the cycle after the byte is accepted. A byte can
// be accepted in every cycle: the only limit is the single result register,
// which is refilled in the same cycle its beat leaves, so the block stalls
// only while a result waits on a low rsp.ready. A record is a doubled header
// byte followed by a little-endian 16-bit value; results come on the high
// value byte (height or arm position), or on the second header byte for an
// undefined header or a header mismatch. After a mismatch every byte up to
// and including the batch_end byte is discarded. Records cut off by batch_end
// give no result. The user must write the position limit through
// csr_write_enable / csr_write_data only while the block is idle (unchecked).
// ---------------------------------------------------------------------------
module feedback_frame_parser (
   input  logic           clock,
   input  logic           reset,
   ffp_req_if.sink        req,
   ffp_rsp_if.source      rsp,
   input  logic           csr_write_enable,
   input  logic [15:0]    csr_write_data
);

   // Parser state.
   ffp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         first_header_ff, first_header_in;
   logic [7:0]         low_byte_ff, low_byte_in;
   logic               dropping_ff, dropping_in;
   logic [15:0]        position_limit_ff;

   // Result register.
   logic                rsp_valid_ff;
   ffp_pkg::status_type rsp_status_ff;
   logic [2:0]          rsp_arm_ff;
   logic [15:0]         rsp_value_ff;

   // Decoded result for the current beat.
   logic                emit;
   ffp_pkg::status_type emit_status;
   logic [2:0]          emit_arm;
   logic [15:0]         emit_value;

   logic        accept;
   logic        is_last;
   logic [7:0]  rx;
   logic [15:0] record_value;
   logic [7:0]  arm_full;
   logic        hdr_known;

   // A new byte is taken whenever the result register is free or draining.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign is_last   = req.batch_end;
   assign rx        = req.rx_byte;

   assign record_value = {rx, low_byte_ff};
   assign arm_full     = ffp_pkg::HDR_BASE - first_header_ff;
   assign hdr_known    = (rx == ffp_pkg::HDR_HEIGHT) ||
                         ((rx >= (ffp_pkg::HDR_BASE - ffp_pkg::ARM_MAX)) &&
                          (rx <= (ffp_pkg::HDR_BASE - ffp_pkg::ARM_MIN)));

   // Next state of the record parser.
   always_comb begin
      phase_in        = phase_ff;
      first_header_in = first_header_ff;
      low_byte_in     = low_byte_ff;
      dropping_in     = dropping_ff;
      if (accept) begin
         if (dropping_ff) begin
            if (is_last) begin
               dropping_in = 1'b0;
               phase_in    = ffp_pkg::PH_HDR1;
            end
         end else begin
            case (phase_ff)
               ffp_pkg::PH_HDR1: begin
                  first_header_in = rx;
                  phase_in = is_last ? ffp_pkg::PH_HDR1 : ffp_pkg::PH_HDR2;
               end
               ffp_pkg::PH_HDR2: begin
                  if (is_last) begin
                     phase_in = ffp_pkg::PH_HDR1;
                  end else if (rx != first_header_ff) begin
                     dropping_in = 1'b1;
                     phase_in    = ffp_pkg::PH_HDR1;
                  end else if (hdr_known) begin
                     phase_in = ffp_pkg::PH_LOW;
                  end else begin
                     phase_in = ffp_pkg::PH_HDR1;
                  end
               end
               ffp_pkg::PH_LOW: begin
                  low_byte_in = rx;
                  phase_in = is_last ? ffp_pkg::PH_HDR1 : ffp_pkg::PH_HIGH;
               end
               ffp_pkg::PH_HIGH: begin
                  phase_in = ffp_pkg::PH_HDR1;
               end
               default: begin
                  phase_in = ffp_pkg::PH_HDR1;
               end
            endcase
         end
      end
   end

   // Result produced by the current beat, if any.
   always_comb begin
      emit        = 1'b0;
      emit_status = ffp_pkg::ST_HEIGHT;
      emit_arm    = 3'd0;
      emit_value  = 16'd0;
      if (!dropping_ff) begin
         case (phase_ff)
            ffp_pkg::PH_HDR2: begin
               if (!is_last && (rx != first_header_ff)) begin
                  emit        = 1'b1;
                  emit_status = ffp_pkg::ST_MISMATCH;
               end else if (!is_last && !hdr_known) begin
                  emit        = 1'b1;
                  emit_status = ffp_pkg::ST_UNDEF;
               end
            end
            ffp_pkg::PH_HIGH: begin
               emit       = 1'b1;
               emit_value = record_value;
               if (first_header_ff == ffp_pkg::HDR_HEIGHT) begin
                  emit_status = ffp_pkg::ST_HEIGHT;
               end else begin
                  emit_arm    = arm_full[2:0];
                  emit_status = (record_value <= position_limit_ff) ?
                                ffp_pkg::ST_ARM_SET : ffp_pkg::ST_REJECT;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // Parser state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= ffp_pkg::PH_HDR1;
         first_header_ff   <= 8'd0;
         low_byte_ff       <= 8'd0;
         dropping_ff       <= 1'b0;
         position_limit_ff <= ffp_pkg::LIMIT_RESET;
      end else begin
         phase_ff        <= phase_in;
         first_header_ff <= first_header_in;
         low_byte_ff     <= low_byte_in;
         dropping_ff     <= dropping_in;
         if (csr_write_enable) begin
            position_limit_ff <= csr_write_data;
         end
      end
   end

   // Result register: loaded on a producing beat, cleared when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_status_ff <= emit_status;
         rsp_arm_ff    <= emit_arm;
         rsp_value_ff  <= emit_value;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.arm_number = rsp_arm_ff;
   assign rsp.value      = rsp_value_ff;

   // A result only appears after an accepted byte.
   a_result_needs_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result appeared without an accepted byte");

   // A reported mismatch starts discarding the rest of the batch.
   a_mismatch_drops: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && (emit_status == ffp_pkg::ST_MISMATCH)) |=> dropping_ff)
      else $error("mismatch did not start dropping");

   // Nothing is reported while the batch is being discarded.
   a_quiet_when_dropping: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> !emit)
      else $error("result produced while dropping");

   // Arm results always carry an arm number in range.
   a_arm_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_status_ff == ffp_pkg::ST_ARM_SET) ||
                        (rsp_status_ff == ffp_pkg::ST_REJECT)))
      |-> ((rsp_arm_ff >= 3'd1) && (rsp_arm_ff <= 3'd5)))
      else $error("arm number out of range");

endmodule

@@ tb/feedback_frame_parser_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Feedback frame parser checker
// Watches the byte and result channels and the position limit register. It
// keeps its own copy of the parser state and predicts the result of every
// accepted byte. Each result beat is compared field by field with the oldest
// prediction still waiting.
// ---------------------------------------------------------------------------
module feedback_frame_parser_checker (
   input  logic        clock,
   input  logic        reset,
   ffp_req_if          req,
   ffp_rsp_if          rsp,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output int          failures,
   output int          outstanding
);

   typedef struct packed {
      ffp_pkg::status_type status;
      logic [2:0]          arm;
      logic [15:0]         value;
   } parse_result_type;

   // Shadow copy of the parser state and the limit register.
   ffp_pkg::phase_type rec_phase;
   logic [7:0]         rec_header;
   logic [7:0]         rec_low;
   logic               skip_batch;
   logic [15:0]        pos_limit;

   parse_result_type predicted_results[$];
   int               mismatch_count;

   // Advances the shadow parser by one byte. Returns 1 when the byte
   // completes something that the block reports.
   function automatic bit parse_byte(input logic [7:0] rx, input logic last,
                                     output parse_result_type res);
      logic [15:0] word;
      logic [7:0]  arm_code;
      bit          hit;
      hit = 1'b0;
      res.status = ffp_pkg::ST_HEIGHT;
      res.arm = 3'd0;
      res.value = 16'd0;
      // After a header mismatch, everything up to the batch end is dropped.
      if (skip_batch) begin
         if (last) begin
            skip_batch = 1'b0;
            rec_phase = ffp_pkg::PH_HDR1;
         end
         return 1'b0;
      end
      case (rec_phase)
         ffp_pkg::PH_HDR1: begin
            rec_header = rx;
            rec_phase = last ? ffp_pkg::PH_HDR1 : ffp_pkg::PH_HDR2;
         end
         ffp_pkg::PH_HDR2: begin
            // A header pair that ends the batch is never checked.
            if (last) begin
               rec_phase = ffp_pkg::PH_HDR1;
            end else if (rx != rec_header) begin
               res.status = ffp_pkg::ST_MISMATCH;
               hit = 1'b1;
               skip_batch = 1'b1;
               rec_phase = ffp_pkg::PH_HDR1;
            end else if (rx == ffp_pkg::HDR_HEIGHT ||
                         (rx >= ffp_pkg::HDR_BASE - ffp_pkg::ARM_MAX &&
                          rx <= ffp_pkg::HDR_BASE - ffp_pkg::ARM_MIN)) begin
               rec_phase = ffp_pkg::PH_LOW;
            end else begin
               res.status = ffp_pkg::ST_UNDEF;
               hit = 1'b1;
               rec_phase = ffp_pkg::PH_HDR1;
            end
         end
         ffp_pkg::PH_LOW: begin
            rec_low = rx;
            rec_phase = last ? ffp_pkg::PH_HDR1 : ffp_pkg::PH_HIGH;
         end
         default: begin
            word = {rx, rec_low};
            res.value = word;
            if (rec_header == ffp_pkg::HDR_HEIGHT) begin
               res.status = ffp_pkg::ST_HEIGHT;
            end else begin
               arm_code = ffp_pkg::HDR_BASE - rec_header;
               res.arm = arm_code[2:0];
               res.status = (word <= pos_limit) ? ffp_pkg::ST_ARM_SET : ffp_pkg::ST_REJECT;
            end
            hit = 1'b1;
            rec_phase = ffp_pkg::PH_HDR1;
         end
      endcase
      return hit;
   endfunction

   // Result beats are handled before byte beats: a result leaving at an edge
   // always belongs to a byte accepted at an earlier edge. A limit write
   // takes effect for bytes after its edge.
   always @(posedge clock) begin
      parse_result_type want;
      parse_result_type pred;
      if (reset) begin
         rec_phase = ffp_pkg::PH_HDR1;
         rec_header = 8'd0;
         rec_low = 8'd0;
         skip_batch = 1'b0;
         pos_limit = ffp_pkg::LIMIT_RESET;
         predicted_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: ERROR unexpected result beat: status %0d arm %0d value 0x%04h",
                        $time, rsp.status, rsp.arm_number, rsp.value);
            end else begin
               want = predicted_results.pop_front();
               if (rsp.status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: ERROR status expected %0d, actual %0d",
                           $time, want.status, rsp.status);
               end
               if (rsp.arm_number !== want.arm) begin
                  mismatch_count++;
                  $display("%0t: ERROR arm_number expected %0d, actual %0d",
                           $time, want.arm, rsp.arm_number);
               end
               if (rsp.value !== want.value) begin
                  mismatch_count++;
                  $display("%0t: ERROR value expected 0x%04h, actual 0x%04h",
                           $time, want.value, rsp.value);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (parse_byte(req.rx_byte, req.batch_end, pred)) begin
               predicted_results.push_back(pred);
            end
         end
         if (csr_write_enable) begin
            pos_limit = csr_write_data;
         end
      end
      outstanding <= predicted_results.size();
      failures <= mismatch_count;
   end

endmodule

@@ tb/feedback_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Feedback frame parser testbench
// Feeds directed and random byte batches of height and arm records, with
// undefined headers, header mismatches, cut-off records and noise. The limit
// register is rewritten between phases with different sender and receiver
// idling. A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module feedback_frame_parser_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 125;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } rx_beat_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   int          failures;
   int          outstanding;

   ffp_req_if req_ch ();
   ffp_rsp_if rsp_ch ();

   rx_beat_type rx_beats[$];
   logic [15:0] cur_limit;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_epoch;
   int          hold_seen;
   int          hold_left;
   int          cycle_count;

   feedback_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   feedback_frame_parser_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // Clock generation.
   always #6 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result receiver. A long hold-off starts whenever the stimulus bumps
   // hold_epoch; otherwise ready follows the stall rate of the phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_seen != hold_epoch) begin
         hold_seen <= hold_epoch;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void add_byte(input logic [7:0] data, input logic last = 1'b0);
      rx_beat_type beat;
      beat.data = data;
      beat.last = last;
      rx_beats.push_back(beat);
   endfunction

   function automatic void add_record(input logic [7:0] header, input logic [15:0] word);
      add_byte(header);
      add_byte(header);
      add_byte(word[7:0]);
      add_byte(word[15:8]);
   endfunction

   // Values cluster on the extremes and around the current limit.
   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return cur_limit + 16'($urandom_range(2)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_arm_header();
      return ffp_pkg::HDR_BASE - 8'($urandom_range(ffp_pkg::ARM_MIN, ffp_pkg::ARM_MAX));
   endfunction

   // Builds one batch: mostly well-formed records, some undefined headers
   // and noise, and sometimes a mismatch or a cut-off record at the end.
   function automatic void add_batch();
      int          n_rec;
      int          sel;
      int          cut;
      logic [7:0]  hdr;
      logic [15:0] word;
      n_rec = $urandom_range(1, 4);
      for (int i = 0; i < n_rec; i++) begin
         sel = $urandom_range(99);
         if (sel < 30) begin
            add_record(ffp_pkg::HDR_HEIGHT, pick_value());
         end else if (sel < 70) begin
            add_record(pick_arm_header(), pick_value());
         end else if (sel < 78) begin
            do begin
               hdr = 8'($urandom_range(255));
            end while (hdr == ffp_pkg::HDR_HEIGHT ||
                       (hdr >= ffp_pkg::HDR_BASE - ffp_pkg::ARM_MAX &&
                        hdr <= ffp_pkg::HDR_BASE - ffp_pkg::ARM_MIN));
            add_byte(hdr);
            add_byte(hdr);
         end else if (sel < 84) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
         end else if (sel < 92) begin
            // Header mismatch; whatever follows is dropped.
            hdr = ($urandom_range(1) != 0) ? ffp_pkg::HDR_HEIGHT : pick_arm_header();
            add_byte(hdr);
            add_byte(hdr ^ 8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            break;
         end else begin
            // Record cut off by the batch end.
            hdr = ($urandom_range(1) != 0) ? ffp_pkg::HDR_HEIGHT : pick_arm_header();
            word = pick_value();
            cut = $urandom_range(1, 3);
            add_byte(hdr);
            if (cut > 1) add_byte(($urandom_range(3) == 0) ? ~hdr : hdr);
            if (cut > 2) add_byte(word[7:0]);
            break;
         end
      end
      rx_beats[rx_beats.size() - 1].last = 1'b1;
   endfunction

   // Sends every queued byte. Valid is lowered only inside a gap, so it is
   // never lowered and raised again at the same edge.
   task automatic send_beats();
      rx_beat_type beat;
      while (rx_beats.size() != 0) begin
         beat = rx_beats.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.rx_byte <= beat.data;
         req_ch.batch_end <= beat.last;
         do @(posedge clock); while (!req_ch.ready);
      end
   endtask

   // Waits until every predicted result has left, plus a few cycles for a
   // byte that is still inside the block without a result.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] limit);
      csr_write_data <= limit;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_limit = limit;
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [15:0] limit, input bit hold);
      wait_drained();
      write_limit(limit);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (hold) hold_epoch++;
      while (rx_beats.size() < PHASE_BYTES) add_batch();
      send_beats();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'd0;
      req_ch.batch_end = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 16'd0;
      cur_limit = ffp_pkg::LIMIT_RESET;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_epoch = 0;
      hold_seen = 0;
      cycle_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed batches at the reset limit.
      add_record(ffp_pkg::HDR_HEIGHT, 16'hFFFF);
      add_record(ffp_pkg::HDR_BASE - ffp_pkg::ARM_MIN, ffp_pkg::LIMIT_RESET);
      add_record(ffp_pkg::HDR_BASE - ffp_pkg::ARM_MAX, ffp_pkg::LIMIT_RESET + 16'd1);
      rx_beats[rx_beats.size() - 1].last = 1'b1;
      // Undefined header pair, then a lone header that ends its batch.
      add_byte(ffp_pkg::HDR_BASE);
      add_byte(ffp_pkg::HDR_BASE);
      add_byte(8'h55, 1'b1);
      // Height record cut off after its low byte.
      add_byte(ffp_pkg::HDR_HEIGHT);
      add_byte(ffp_pkg::HDR_HEIGHT);
      add_byte(8'hFF, 1'b1);
      // Unequal pair at the batch end is not reported.
      add_byte(8'h37);
      add_byte(8'hC8, 1'b1);
      // Header mismatch drops the rest of the batch.
      add_byte(ffp_pkg::HDR_HEIGHT);
      add_byte(8'h11);
      add_byte(ffp_pkg::HDR_HEIGHT);
      add_byte(ffp_pkg::HDR_HEIGHT, 1'b1);
      add_record(ffp_pkg::HDR_BASE - ffp_pkg::ARM_MIN, 16'h0000);
      rx_beats[rx_beats.size() - 1].last = 1'b1;
      send_beats();

      // Random phases.
      run_phase(0, 0, ffp_pkg::LIMIT_RESET, 1'b0);
      run_phase(82, 0, 16'h0000, 1'b0);
      run_phase(0, 82, 16'hFFFF, 1'b0);
      run_phase(30, 30, 16'($urandom), 1'b0);
      run_phase(0, 0, 16'($urandom_range(500, 40000)), 1'b1);
      run_phase(30, 30, 16'd1, 1'b0);
      run_phase(0, 0, ffp_pkg::LIMIT_RESET, 1'b0);

      wait_drained();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
